// ===== src/htfd_pkg.sv =====
// Shared types, constants and arithmetic helpers for the sensor frame decoder.
// No dependencies; imported by every module of the block.
package htfd_pkg;

  localparam logic [7:0]  CrcPoly   = 8'h31;
  localparam logic [7:0]  CrcInit   = 8'hFF;
  localparam logic [17:0] TempSpan  = 18'd175000;
  localparam logic [17:0] TempOff   = 18'd45000;
  localparam logic [16:0] HumSpan   = 17'd100000;
  localparam logic [16:0] FullScale = 17'd65535;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTempCrc = 2'd1,
    StatusHumCrc  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] t_word;
    logic [15:0] h_word;
    status_e     status;
  } frame_t;

  typedef struct packed {
    logic signed [17:0] temp_milli;
    logic [16:0]        rh_milli;
    logic [15:0]        t_word;
    logic [15:0]        h_word;
    status_e            status;
  } result_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2**34, via 65536 = 65535 + 1 folding
  function automatic logic [17:0] div65535(logic [33:0] x);
    logic [17:0] q0;
    logic [18:0] r0;
    logic [2:0]  q1;
    logic [16:0] r1;
    logic        c;
    q0 = x[33:16];
    r0 = {3'b0, x[15:0]} + {1'b0, q0};
    q1 = r0[18:16];
    r1 = {1'b0, r0[15:0]} + {14'b0, q1};
    c  = (r1 >= FullScale);
    return q0 + {15'b0, q1} + {17'b0, c};
  endfunction

endpackage

// ===== src/htfd_front.sv =====
// Front part: takes frame bytes, tracks position and CRC, classifies frames.
// Completed frames wait in a two-entry queue for the back part. Uses htfd_pkg.
module htfd_front import htfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       fr_valid_o,
  output frame_t     fr_data_o,
  input  logic       fr_take_i
);

  logic [2:0]  pos_q, pos_d, pos_cur;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] hum_q, hum_d;
  logic        tgood_q, tgood_d;
  logic        accept, mid_push, mid_pop;
  frame_t      frame_new;
  frame_t      mid_mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full    = (cnt_q == 2'd2);
  assign accept  = push && !full;
  assign pos_cur = frame_start_i ? 3'd0 : pos_q;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    temp_d  = temp_q;
    hum_d   = hum_q;
    tgood_d = tgood_q;
    frame_new.t_word = temp_q;
    frame_new.h_word = hum_q;
    if (!tgood_q) begin
      frame_new.status = StatusTempCrc;
    end else if (crc_q != rx_byte_i) begin
      frame_new.status = StatusHumCrc;
    end else begin
      frame_new.status = StatusOk;
    end
    mid_push = 1'b0;
    if (accept) begin
      pos_d = pos_cur + 3'd1;
      unique case (pos_cur)
        3'd0: begin
          crc_d  = crc8_byte(CrcInit, rx_byte_i);
          temp_d = {rx_byte_i, 8'h00};
        end
        3'd1: begin
          crc_d  = crc8_byte(crc_q, rx_byte_i);
          temp_d = {temp_q[15:8], rx_byte_i};
        end
        3'd2: begin
          tgood_d = (crc_q == rx_byte_i);
          crc_d   = CrcInit;
        end
        3'd3: begin
          crc_d = crc8_byte(CrcInit, rx_byte_i);
          hum_d = {rx_byte_i, 8'h00};
        end
        3'd4: begin
          crc_d = crc8_byte(crc_q, rx_byte_i);
          hum_d = {hum_q[15:8], rx_byte_i};
        end
        default: begin
          pos_d    = 3'd0;
          crc_d    = CrcInit;
          mid_push = 1'b1;
        end
      endcase
    end
  end

  assign mid_pop    = fr_take_i && (cnt_q != 2'd0);
  assign fr_valid_o = (cnt_q != 2'd0);
  assign fr_data_o  = mid_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      crc_q    <= CrcInit;
      tgood_q  <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tgood_q <= tgood_d;
      if (mid_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (mid_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, mid_push} - {1'b0, mid_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    hum_q  <= hum_d;
    if (mid_push) begin
      mid_mem_q[wr_ptr_q] <= frame_new;
    end
  end

endmodule

// ===== src/htfd_back.sv =====
// Back part: scales raw words, keeps the last good values, queues results.
// Two stages (multiply, then divide by full scale) feed a four-entry queue. Uses htfd_pkg.
module htfd_back import htfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fr_valid_i,
  input  frame_t  fr_data_i,
  output logic    fr_take_o,
  output logic    empty,
  input  logic    pop,
  output result_t res_o
);

  logic               a_valid_q;
  logic [33:0]        a_tprod_q;
  logic [32:0]        a_hprod_q;
  frame_t             a_frame_q;
  logic signed [17:0] last_temp_q, last_temp_d;
  logic [16:0]        last_hum_q, last_hum_d;
  logic [17:0]        tq, hq;
  result_t            res_new;
  result_t            out_mem_q [4];
  logic [1:0]         wr_ptr_q, rd_ptr_q;
  logic [2:0]         cnt_q;
  logic               out_pop;

  assign fr_take_o = fr_valid_i && (({1'b0, cnt_q} + {3'b0, a_valid_q}) < 4'd4);

  always_comb begin
    tq = div65535(a_tprod_q);
    hq = div65535({1'b0, a_hprod_q});
    last_temp_d = last_temp_q;
    last_hum_d  = last_hum_q;
    if (a_frame_q.status == StatusOk) begin
      last_temp_d = $signed(tq - TempOff);
      last_hum_d  = hq[16:0];
    end
    res_new.temp_milli = last_temp_d;
    res_new.rh_milli   = last_hum_d;
    res_new.t_word     = a_frame_q.t_word;
    res_new.h_word     = a_frame_q.h_word;
    res_new.status     = a_frame_q.status;
  end

  assign empty   = (cnt_q == 3'd0);
  assign out_pop = pop && !empty;
  assign res_o   = out_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      last_temp_q <= '0;
      last_hum_q  <= '0;
      wr_ptr_q    <= 2'd0;
      rd_ptr_q    <= 2'd0;
      cnt_q       <= 3'd0;
    end else begin
      a_valid_q <= fr_take_o;
      if (a_valid_q) begin
        last_temp_q <= last_temp_d;
        last_hum_q  <= last_hum_d;
        wr_ptr_q    <= wr_ptr_q + 2'd1;
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {2'b0, a_valid_q} - {2'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_take_o) begin
      a_tprod_q <= TempSpan * {18'b0, fr_data_i.t_word};
      a_hprod_q <= HumSpan * {17'b0, fr_data_i.h_word};
      a_frame_q <= fr_data_i;
    end
    if (a_valid_q) begin
      out_mem_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

// ===== src/humidity_temp_frame_decoder.sv =====
// Top level of the sensor frame decoder: front classifier and back converter.
// Depends on htfd_pkg, htfd_front and htfd_back.
//
// Usage: frame bytes enter through a queue-like port (push/full), one byte per
// item, in wire order; frame_start_i marks byte zero and resynchronizes the
// frame count. After the sixth byte one result is queued on the output side
// (empty/pop): converted temperature and humidity, both raw words and status.
// On a CRC error the last good converted values are repeated.
// The sixth byte's frame passes the frame queue and the multiply register into
// the result queue. Throughput: one byte per cycle while full is low; the CRC
// update, the multiply stage and divide-by-full-scale stage are registered.
// full rises only while the two-entry frame queue between front and back is
// full; the back part stops drawing frames while its four-entry result queue,
// counting the one frame in flight, has no room. A stalled receiver thus
// backs up through both queues to the input without losing any item.
// Reset clears the frame position, the CRC, both queues and the last good
// values (zero temperature and humidity).
module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [17:0] temp_milli_o,
  output logic [16:0]        rh_milli_o,
  output logic [15:0]        raw_temperature_o,
  output logic [15:0]        raw_humidity_o,
  output logic [1:0]         frame_status_o
);

  logic    fr_valid, fr_take;
  frame_t  fr_data;
  result_t res;

  htfd_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .rx_byte_i,
    .frame_start_i,
    .fr_valid_o (fr_valid),
    .fr_data_o  (fr_data),
    .fr_take_i  (fr_take)
  );

  htfd_back u_back (
    .clk_i,
    .rst_ni,
    .fr_valid_i (fr_valid),
    .fr_data_i  (fr_data),
    .fr_take_o  (fr_take),
    .empty,
    .pop,
    .res_o      (res)
  );

  assign temp_milli_o      = res.temp_milli;
  assign rh_milli_o        = res.rh_milli;
  assign raw_temperature_o = res.t_word;
  assign raw_humidity_o    = res.h_word;
  assign frame_status_o    = res.status;

endmodule

// ===== verif/htfd_tb_pkg.sv =====
// CRC-8 helper and constants shared by the frame decoder testbench files.
// No dependencies; imported by the checker and the testbench top.
package htfd_tb_pkg;

  localparam logic [7:0] CrcSeed = 8'hFF;
  localparam logic [7:0] CrcPolynomial = 8'h31;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPolynomial) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== verif/htfd_frame_checker.sv =====
// Checker for the frame decoder: predicts results from accepted bytes and
// compares them with accepted results. Depends on htfd_pkg and htfd_tb_pkg.
module htfd_frame_checker import htfd_pkg::*, htfd_tb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [17:0] temp_milli_i,
  input  logic [16:0]        rh_milli_i,
  input  logic [15:0]        raw_temperature_i,
  input  logic [15:0]        raw_humidity_i,
  input  logic [1:0]         frame_status_i,
  output int                 fail_count_o,
  output int                 open_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FinalPosition = 3'd5;

  logic [2:0]         position;
  logic [7:0]         word_crc;
  logic [15:0]        temp_raw;
  logic [15:0]        hum_raw;
  logic               temp_crc_ok;
  logic signed [17:0] good_temp;
  logic [16:0]        good_hum;
  result_t            expected_frames[$];
  result_t            want;
  int                 errors = 0;

  task automatic absorb_byte(input logic [7:0] b, input logic start);
    result_t  r;
    longint   scaled;
    if (start) position = '0;
    if (position > FinalPosition) position = '0;
    unique case (position)
      3'd0: begin
        word_crc = crc8_update(CrcSeed, b);
        temp_raw = {b, 8'h00};
      end
      3'd1: begin
        word_crc = crc8_update(word_crc, b);
        temp_raw[7:0] = b;
      end
      3'd2: begin
        temp_crc_ok = (word_crc == b);
        word_crc = CrcSeed;
      end
      3'd3: begin
        word_crc = crc8_update(CrcSeed, b);
        hum_raw = {b, 8'h00};
      end
      3'd4: begin
        word_crc = crc8_update(word_crc, b);
        hum_raw[7:0] = b;
      end
      default: ;
    endcase
    if (position < FinalPosition) begin
      position = position + 3'd1;
    end else begin
      if (!temp_crc_ok) begin
        r.status = StatusTempCrc;
      end else if (word_crc != b) begin
        r.status = StatusHumCrc;
      end else begin
        scaled = (longint'(temp_raw) * 175000) / 65535;
        good_temp = 18'(scaled - 45000);
        scaled = (longint'(hum_raw) * 100000) / 65535;
        good_hum = 17'(scaled);
        r.status = StatusOk;
      end
      r.temp_milli = good_temp;
      r.rh_milli = good_hum;
      r.t_word = temp_raw;
      r.h_word = hum_raw;
      expected_frames.push_back(r);
      position = '0;
      word_crc = CrcSeed;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position = '0;
      word_crc = CrcSeed;
      temp_raw = '0;
      hum_raw = '0;
      temp_crc_ok = 1'b0;
      good_temp = '0;
      good_hum = '0;
      expected_frames.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: status %0d raw_temperature %0h", frame_status_i,
                 raw_temperature_i);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (temp_milli_i !== want.temp_milli) begin
            $error("temp_milli: expected %0d, got %0d", want.temp_milli,
                   temp_milli_i);
            errors++;
          end
          if (rh_milli_i !== want.rh_milli) begin
            $error("rh_milli: expected %0d, got %0d", want.rh_milli, rh_milli_i);
            errors++;
          end
          if (raw_temperature_i !== want.t_word) begin
            $error("raw_temperature: expected %0h, got %0h", want.t_word,
                   raw_temperature_i);
            errors++;
          end
          if (raw_humidity_i !== want.h_word) begin
            $error("raw_humidity: expected %0h, got %0h", want.h_word, raw_humidity_i);
            errors++;
          end
          if (frame_status_i !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, frame_status_i);
            errors++;
          end
        end
      end
      if (push && !full) absorb_byte(rx_byte_i, frame_start_i);
    end
    fail_count_o <= errors;
    open_results_o <= expected_frames.size();
  end

endmodule

// ===== verif/tb_humidity_temp_frame_decoder.sv =====
// Testbench top for the frame decoder: drives directed and random frames
// under several idle and stall patterns and gives the verdict. Depends on htfd_pkg,
// htfd_tb_pkg, htfd_frame_checker and humidity_temp_frame_decoder.
module tb_humidity_temp_frame_decoder import htfd_pkg::*, htfd_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int PhaseItems = 420;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         rx_byte = '0;
  logic               frame_start = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [17:0] temp_milli;
  logic [16:0]        rh_milli;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;
  logic [1:0]         frame_status;
  int                 fail_count;
  int                 open_results;
  int unsigned        cycles = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 items_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  humidity_temp_frame_decoder i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .empty              (empty),
    .pop                (pop),
    .temp_milli_o       (temp_milli),
    .rh_milli_o         (rh_milli),
    .raw_temperature_o  (raw_temperature),
    .raw_humidity_o     (raw_humidity),
    .frame_status_o     (frame_status)
  );

  htfd_frame_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte),
    .frame_start_i      (frame_start),
    .empty              (empty),
    .pop                (pop),
    .temp_milli_i       (temp_milli),
    .rh_milli_i         (rh_milli),
    .raw_temperature_i  (raw_temperature),
    .raw_humidity_i     (raw_humidity),
    .frame_status_i     (frame_status),
    .fail_count_o       (fail_count),
    .open_results_o     (open_results)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte <= b;
    frame_start <= start;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic bad_t, input logic bad_h, input logic mark);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc8_update(crc8_update(CrcSeed, tw[15:8]), tw[7:0]);
    hc = crc8_update(crc8_update(CrcSeed, hw[15:8]), hw[7:0]);
    if (bad_t) tc ^= 8'($urandom_range(255, 1));
    if (bad_h) hc ^= 8'($urandom_range(255, 1));
    send_item(tw[15:8], mark);
    send_item(tw[7:0], 1'b0);
    send_item(tc, 1'b0);
    send_item(hw[15:8], 1'b0);
    send_item(hw[7:0], 1'b0);
    send_item(hc, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    unique case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (open_results != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int target);
    int kind;
    int n;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        send_frame(pick_word(), pick_word(), $urandom_range(99) < 10,
                   $urandom_range(99) < 10, $urandom_range(99) < 85);
      end else if (kind < 90) begin
        n = $urandom_range(4);
        send_item(8'($urandom), 1'b1);
        repeat (n) send_item(8'($urandom), 1'b0);
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(8'($urandom), $urandom_range(5) == 0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmarked first frame, humidity CRC error before any good frame
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    // both CRCs bad: temperature error wins, good values repeat
    send_frame(16'h8000, 16'h1234, 1'b1, 1'b1, 1'b1);
    // partial frame dropped by a new start mark
    send_item(8'h12, 1'b1);
    send_item(8'h34, 1'b0);
    send_item(8'h56, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    drain_results();

    idle_pct = 0;
    stall_pct <= 0;
    run_phase(items_sent + PhaseItems);
    drain_results();

    idle_pct = 51;
    stall_pct <= 0;
    run_phase(items_sent + PhaseItems);
    drain_results();

    idle_pct = 0;
    stall_pct <= 51;
    run_phase(items_sent + PhaseItems);
    drain_results();

    idle_pct = 22;
    stall_pct <= 22;
    run_phase(items_sent + PhaseItems);
    drain_results();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/htfd_pkg.sv
src/htfd_front.sv
src/htfd_back.sv
src/humidity_temp_frame_decoder.sv
verif/htfd_tb_pkg.sv
verif/htfd_frame_checker.sv
verif/tb_humidity_temp_frame_decoder.sv
